[rtl/tlpt_pkg.sv]
// Shared types and constants for the two-level page table mapper.
// Used by the channel interfaces, the controller, the datapath and the top level.
package tlpt_pkg;

  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned FLAG_W            = 12;
  localparam int unsigned FNUM_W            = 20;
  localparam int unsigned ENTRIES_PER_TABLE = 1024;
  localparam int unsigned IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int unsigned NUM_FRAMES_DEF    = 64;
  localparam int unsigned BASE_FRAME_DEF    = 262144;
  localparam int unsigned CFG_IDX_W         = 1;

  localparam logic [ADDR_W-1:0] ADDR_MASK = 32'hFFFF_F000;

  localparam logic [CFG_IDX_W-1:0] CFG_USER_RW   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_RW = 1'b1;

  localparam logic [FLAG_W-1:0] USER_RW_RST   = 12'd7;
  localparam logic [FLAG_W-1:0] KERNEL_RW_RST = 12'd3;

  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_UNMAP = 2'd1,
    CMD_XLATE = 2'd2,
    CMD_SETFL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_TABLE = 2'd1,
    ST_NO_FRAME = 2'd2,
    ST_OUT_POOL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_IN,
    RD_DIR,
    RD_TBL
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_CLR,
    WR_DIR_NEW,
    WR_DIR_FLAGS,
    WR_ENT
  } wr_sel_t;

  typedef struct packed {
    logic    latch;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    t_load;
    logic    t_take;
    logic    take;
    logic    push;
    logic    sweep_clr;
    logic    sweep_inc;
    logic    out_load;
    status_t out_status;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic is_make;
    logic dflags_nz;
    logic dir_zero;
    logic frame_out;
    logic ent_bad;
    logic take_ok;
    logic out_free;
    logic init_done;
    logic clr_done;
  } dp_stat_t;

endpackage

[rtl/tlpt_if.sv]
// Valid/ready channel interfaces for command beats and result beats.
// Depends on tlpt_pkg for field widths.
interface tlpt_in_if import tlpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [ADDR_W-1:0] vaddr;
  logic [FLAG_W-1:0] page_flags;

  modport source (output valid, output cmd, output vaddr, output page_flags, input ready);
  modport sink   (input valid, input cmd, input vaddr, input page_flags, output ready);
endinterface

interface tlpt_out_if import tlpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] paddr;

  modport source (output valid, output status, output paddr, input ready);
  modport sink   (input valid, input status, input paddr, output ready);
endinterface

[rtl/two_level_page_table_mapper_top.sv]
// Two-level page table mapper: after reset the block clears its table store,
// one word a cycle, and takes no command until then; configuration writes are
// taken at any time. A command then goes from the accepted beat to the result
// beat through directory read, directory check, table entry read, entry update
// and result; the single read port of the table store keeps these steps apart.
// A map or set-flags command that finds no table clears the new table frame
// first. Depends on tlpt_pkg, tlpt_if, tlpt_ctrl and tlpt_dp.
module two_level_page_table_mapper_top import tlpt_pkg::*; #(
  parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int unsigned BASE_FRAME = BASE_FRAME_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tlpt_in_if.sink              in_ch,
  tlpt_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FLAG_W-1:0]    cfg_wdata
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  tlpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  tlpt_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .BASE_FRAME (BASE_FRAME)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_cmd        (in_ch.cmd),
    .in_vaddr      (in_ch.vaddr),
    .in_page_flags (in_ch.page_flags),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_status    (out_ch.status),
    .out_paddr     (out_ch.paddr),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .ctl           (ctl),
    .stat          (stat)
  );

endmodule

[rtl/tlpt_ctrl.sv]
// Controller for the page table mapper: sequences the clearing pass, the
// directory and table accesses. Depends on tlpt_pkg; drives tlpt_dp.
module tlpt_ctrl import tlpt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIR,
    S_CLR,
    S_DIR_WR,
    S_TBL_RD,
    S_TBL
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r, ready_nxt;

  always_comb begin
    ctl            = '0;
    ctl.rd_sel     = RD_IN;
    ctl.wr_sel     = WR_NONE;
    ctl.out_status = ST_OK;
    state_nxt      = state_r;
    case (state_r)
      S_INIT: begin
        ctl.wr_sel    = WR_INIT;
        ctl.sweep_inc = 1'b1;
        if (stat.init_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        ctl.rd_sel = RD_IN;
        if (in_valid && ready_r) begin
          ctl.latch = 1'b1;
          state_nxt = S_DIR;
        end
      end
      S_DIR: begin
        // hold the directory read so the entry stays put while the output stalls
        ctl.rd_sel = RD_DIR;
        if (stat.dir_zero) begin
          if (stat.is_make && stat.take_ok) begin
            ctl.t_load    = 1'b1;
            ctl.t_take    = 1'b1;
            ctl.take      = 1'b1;
            ctl.sweep_clr = 1'b1;
            state_nxt     = S_CLR;
          end else if (stat.out_free) begin
            ctl.out_load   = 1'b1;
            ctl.out_status = stat.is_make ? ST_NO_FRAME : ST_NO_TABLE;
            state_nxt      = S_IDLE;
          end
        end else if (stat.frame_out) begin
          if (stat.out_free) begin
            ctl.out_load   = 1'b1;
            ctl.out_status = ST_OUT_POOL;
            state_nxt      = S_IDLE;
          end
        end else begin
          ctl.t_load = 1'b1;
          if (stat.is_make && stat.dflags_nz) ctl.wr_sel = WR_DIR_FLAGS;
          state_nxt = S_TBL_RD;
        end
      end
      S_CLR: begin
        ctl.wr_sel    = WR_CLR;
        ctl.sweep_inc = 1'b1;
        if (stat.clr_done) state_nxt = S_DIR_WR;
      end
      S_DIR_WR: begin
        ctl.wr_sel = WR_DIR_NEW;
        state_nxt  = S_TBL_RD;
      end
      S_TBL_RD: begin
        ctl.rd_sel = RD_TBL;
        state_nxt  = S_TBL;
      end
      S_TBL: begin
        ctl.rd_sel = RD_TBL;
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
          case (stat.cmd)
            CMD_MAP: begin
              if (stat.take_ok) begin
                ctl.take   = 1'b1;
                ctl.wr_sel = WR_ENT;
              end else begin
                ctl.out_status = ST_NO_FRAME;
              end
            end
            CMD_UNMAP: begin
              if (stat.ent_bad) begin
                ctl.out_status = ST_OUT_POOL;
              end else begin
                ctl.push   = 1'b1;
                ctl.wr_sel = WR_ENT;
              end
            end
            CMD_SETFL: ctl.wr_sel = WR_ENT;
            default:   ctl.wr_sel = WR_NONE;
          endcase
        end
      end
      default: state_nxt = S_INIT;
    endcase
    ready_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign in_ready = ready_r;

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> state_r == S_IDLE) else $error("ready outside idle");
  a_take_guard: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take |-> stat.take_ok) else $error("frame taken from empty pool");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> stat.out_free) else $error("result overwritten");
`endif

endmodule

[rtl/tlpt_dp.sv]
// Datapath for the page table mapper: table store, freed-frame stack,
// frame counters, config registers and result register. Depends on tlpt_pkg.
module tlpt_dp import tlpt_pkg::*; #(
  parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF,
  parameter int unsigned BASE_FRAME = BASE_FRAME_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_cmd,
  input  logic [ADDR_W-1:0]    in_vaddr,
  input  logic [FLAG_W-1:0]    in_page_flags,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [ADDR_W-1:0]    out_paddr,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FLAG_W-1:0]    cfg_wdata,
  input  dp_cmd_t              ctl,
  output dp_stat_t             stat
);

  localparam int unsigned FW    = $clog2(NUM_FRAMES);
  localparam int unsigned CW    = $clog2(NUM_FRAMES + 1);
  localparam int unsigned AW    = FW + IDX_W;
  localparam int unsigned DEPTH = NUM_FRAMES * ENTRIES_PER_TABLE;
  localparam logic [AW-1:0]     SWEEP_LAST = AW'(DEPTH - 1);
  localparam logic [FNUM_W-1:0] BASE_FNUM  = FNUM_W'(BASE_FRAME);
  localparam logic [CW-1:0]     NF_C       = CW'(NUM_FRAMES);

  function automatic logic [ADDR_W-1:0] fbase(input logic [FW-1:0] idx);
    logic [FNUM_W-1:0] fn;
    fn = BASE_FNUM + FNUM_W'(idx);
    return {fn, 12'h000};
  endfunction

  logic [ADDR_W-1:0] mem [DEPTH];
  logic [FW-1:0]     stk [NUM_FRAMES];

  cmd_t              cmd_r;
  logic [ADDR_W-1:0] vaddr_r;
  logic [FLAG_W-1:0] flags_r;
  logic [FLAG_W-1:0] user_rw_r, kern_rw_r;
  logic [FW-1:0]     t_r, t_nxt;
  logic [AW-1:0]     sweep_r, sweep_nxt;
  logic [CW-1:0]     count_r, count_nxt, cnt_m1;
  logic [CW-1:0]     next_r, next_nxt;
  logic [FW-1:0]     top_r;
  logic [ADDR_W-1:0] rdata_r;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        status_r;
  logic [ADDR_W-1:0] paddr_r, paddr_nxt;

  logic [FLAG_W-1:0] dflags;
  logic [ADDR_W-1:0] ent_addr;
  logic [FNUM_W-1:0] diff;
  logic [FW-1:0]     take_idx;
  logic              take_ok, push_do;
  logic [AW-1:0]     dir_a, tbl_a, rd_a, wr_a;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_d;

  assign dflags   = (cmd_r == CMD_MAP) ? flags_r : user_rw_r;
  assign ent_addr = rdata_r & ADDR_MASK;
  assign diff     = rdata_r[ADDR_W-1:12] - BASE_FNUM;
  assign take_ok  = (count_r != '0) || (next_r < NF_C);
  assign take_idx = (count_r != '0) ? top_r : next_r[FW-1:0];
  assign push_do  = ctl.push && (count_r < NF_C);
  assign dir_a    = {FW'(0), vaddr_r[31:22]};
  assign tbl_a    = {t_r, vaddr_r[21:12]};

  always_comb begin
    case (ctl.rd_sel)
      RD_IN:   rd_a = {FW'(0), in_vaddr[31:22]};
      RD_DIR:  rd_a = dir_a;
      RD_TBL:  rd_a = tbl_a;
      default: rd_a = dir_a;
    endcase
  end

  always_comb begin
    wr_en = 1'b1;
    wr_a  = tbl_a;
    wr_d  = '0;
    case (ctl.wr_sel)
      WR_INIT: wr_a = sweep_r;
      WR_CLR:  wr_a = {t_r, sweep_r[IDX_W-1:0]};
      WR_DIR_NEW: begin
        wr_a = dir_a;
        wr_d = fbase(t_r) | ADDR_W'(dflags);
      end
      WR_DIR_FLAGS: begin
        wr_a = dir_a;
        wr_d = ent_addr | ADDR_W'(dflags);
      end
      WR_ENT: begin
        case (cmd_r)
          CMD_MAP:   wr_d = fbase(take_idx) | ADDR_W'(flags_r);
          CMD_UNMAP: wr_d = ent_addr | ADDR_W'(kern_rw_r);
          default:   wr_d = ent_addr | ADDR_W'(flags_r);
        endcase
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd_r)
      CMD_MAP:   paddr_nxt = fbase(take_idx);
      CMD_XLATE: paddr_nxt = ent_addr + ADDR_W'(vaddr_r[11:0]);
      default:   paddr_nxt = ent_addr;
    endcase
    if (ctl.out_status != ST_OK) paddr_nxt = '0;
  end

  always_comb begin
    t_nxt     = ctl.t_take ? take_idx : diff[FW-1:0];
    sweep_nxt = ctl.sweep_clr ? '0 : (ctl.sweep_inc ? sweep_r + AW'(1) : sweep_r);
    count_nxt = count_r;
    next_nxt  = next_r;
    if (ctl.take) begin
      if (count_r != '0) count_nxt = count_r - CW'(1);
      else               next_nxt  = next_r + CW'(1);
    end else if (push_do) begin
      count_nxt = count_r + CW'(1);
    end
    cnt_m1        = count_nxt - CW'(1);
    out_valid_nxt = ctl.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_a] <= wr_d;
    rdata_r <= mem[rd_a];
    if (push_do) stk[count_r[FW-1:0]] <= diff[FW-1:0];
    // bypass a fresh push so the top is ready next cycle
    top_r <= push_do ? diff[FW-1:0] : stk[cnt_m1[FW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r   <= cmd_t'(in_cmd);
      vaddr_r <= in_vaddr;
      flags_r <= in_page_flags;
    end
    if (ctl.t_load) t_r <= t_nxt;
    if (ctl.out_load) begin
      status_r <= ctl.out_status;
      paddr_r  <= paddr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      count_r     <= '0;
      next_r      <= CW'(1);
      out_valid_r <= 1'b0;
      user_rw_r   <= USER_RW_RST;
      kern_rw_r   <= KERNEL_RW_RST;
    end else begin
      sweep_r     <= sweep_nxt;
      count_r     <= count_nxt;
      next_r      <= next_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_USER_RW:   user_rw_r <= cfg_wdata;
          CFG_KERNEL_RW: kern_rw_r <= cfg_wdata;
          default:       user_rw_r <= user_rw_r;
        endcase
      end
    end
  end

  always_comb begin
    stat.cmd       = cmd_r;
    stat.is_make   = (cmd_r == CMD_MAP) || (cmd_r == CMD_SETFL);
    stat.dflags_nz = (dflags != '0);
    stat.dir_zero  = (ent_addr == '0);
    stat.frame_out = (diff >= FNUM_W'(NUM_FRAMES));
    stat.ent_bad   = (diff >= FNUM_W'(NUM_FRAMES)) || (diff == '0);
    stat.take_ok   = take_ok;
    stat.out_free  = !out_valid_r || out_ready;
    stat.init_done = (sweep_r == SWEEP_LAST);
    stat.clr_done  = (sweep_r[IDX_W-1:0] == '1);
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_paddr  = paddr_r;

`ifndef NO_ASSERTIONS
  a_count_rng: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NF_C) else $error("freed count beyond pool");
  a_next_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (next_r != '0) && (next_r <= NF_C)) else $error("bump counter out of range");
  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !stat.ent_bad) else $error("freeing frame outside pool");
  a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take && (count_r != '0) |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not step freed count");
`endif

endmodule
